// File: src/piecewise_linear_curve_lookup_unit_defines.svh
// Assertion macros shared by the curve lookup RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled in reset
`define PLCL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset
`define PLCL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLCL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PLCL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: src/plcl_pkg.sv
// Shared types and constants for the curve lookup unit.
// No dependencies; used by the interfaces, controller, datapath and top level.
package plcl_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_FIELD_W   = 5;
  localparam int CNT_FIELD_W   = 6;
  localparam int DEF_MAX_PAIRS = 32;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic step;
    logic prep;
    logic mul;
    logic div_step;
    logic ld_pass;
    logic ld_y;
    logic ld_interp;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic hit;
    logic last;
    logic div_last;
    logic out_full;
  } sts_t;

endpackage

// File: src/plcl_if.sv
// Request and response channel interfaces of the curve lookup unit.
// Depends on plcl_pkg for the field widths.
interface plcl_req_if import plcl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [IDX_FIELD_W-1:0] entry_index;
  logic signed [DATA_W-1:0] sample;
  logic signed [DATA_W-1:0] point_y;

  modport source (output valid, opcode, entry_index, sample, point_y, input ready);
  modport sink   (input valid, opcode, entry_index, sample, point_y, output ready);
endinterface

interface plcl_rsp_if import plcl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] curve_value;

  modport source (output valid, curve_value, input ready);
  modport sink   (input valid, curve_value, output ready);
endinterface

// File: src/plcl_ctrl.sv
// Sequencing state machine of the curve lookup unit.
// Depends on plcl_pkg and the assertion macro header.
`include "piecewise_linear_curve_lookup_unit_defines.svh"

module plcl_ctrl import plcl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_opcode,
  output logic req_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req_opcode == OP_LOOKUP) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (sts.n_zero || sts.n_one || sts.hit) state_next = ST_RESULT;
        else state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.hit) state_next = ST_MUL;
        else if (sts.last) state_next = ST_RESULT;
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_next = ST_FIN;
      end
      ST_FIN:  state_next = ST_RESULT;
      ST_RESULT: begin
        if (!sts.out_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_opcode == OP_WRITE) cmd.wr = 1'b1;
          else cmd.start = 1'b1;
        end
      end
      ST_FIRST: begin
        if (sts.n_zero) cmd.ld_pass = 1'b1;
        else if (sts.n_one || sts.hit) cmd.ld_y = 1'b1;
        else cmd.step = 1'b1;
      end
      ST_WALK: begin
        if (sts.hit) cmd.prep = 1'b1;
        else if (sts.last) cmd.ld_y = 1'b1;
        else cmd.step = 1'b1;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIN:  cmd.ld_interp = 1'b1;
      ST_RESULT: begin
        if (!sts.out_full) cmd.push = 1'b1;
      end
      default: ;
    endcase
  end

  `PLCL_ASSERT_IMP(a_step_not_last, clk, rst, cmd.step, !sts.last, "walk advanced past last pair")
  `PLCL_ASSERT_IMP(a_push_free, clk, rst, cmd.push, !sts.out_full, "result pushed onto full output")
  `PLCL_ASSERT_IMP(a_fin_after_div, clk, rst, state == ST_FIN, $past(state) == ST_DIV, "interpolation finished without divide")

endmodule

// File: src/plcl_dp.sv
// Curve lookup unit datapath: breakpoint memories, walk registers, multiplier,
// restoring divider, output register. Depends on plcl_pkg and the macro header.
`include "piecewise_linear_curve_lookup_unit_defines.svh"

module plcl_dp import plcl_pkg::*; #(
  parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CNT_FIELD_W-1:0]   cfg_wr_data,
  input  logic [IDX_FIELD_W-1:0]   req_entry_index,
  input  logic signed [DATA_W-1:0] req_sample,
  input  logic signed [DATA_W-1:0] req_point_y,
  input  logic                     rsp_ready,
  output logic                     rsp_valid,
  output logic signed [DATA_W-1:0] rsp_curve_value,
  input  cmd_t                     cmd,
  output sts_t                     sts
);

  localparam int IDX_W = $clog2(MAX_PAIRS);
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  logic [CNT_FIELD_W-1:0] pair_count;

  logic [DATA_W-1:0] x_mem [MAX_PAIRS];
  logic [DATA_W-1:0] y_mem [MAX_PAIRS];
  logic [DATA_W-1:0] x_rd, y_rd;
  logic [DATA_W-1:0] x0, y0;

  logic [DATA_W-1:0] sample_r;
  logic [CNT_W-1:0]  n_r, k, k_inc;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic              wr_ok;

  logic [DATA_W:0]   dy, dt_w, dx_w;
  logic              neg;
  logic [DATA_W-1:0] mag, dt, dx;
  logic [2*DATA_W-1:0] prod;

  logic [DATA_W-1:0]  rem, qsh;
  logic [DATA_W:0]    trial, diff;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] interp;
  logic              out_full;
  logic [DATA_W-1:0] out_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
    end else if (cfg_wr_en) begin
      pair_count <= cfg_wr_data;
    end
  end

  // Breakpoint memories: one write port from the request, one registered read port
  assign wr_ok   = cmd.wr && (32'(req_entry_index) < MAX_PAIRS);
  assign wr_addr = IDX_W'(req_entry_index);
  assign k_inc   = k + CNT_W'(1);
  assign rd_addr = cmd.start ? '0 : k_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      x_mem[wr_addr] <= req_sample;
      y_mem[wr_addr] <= req_point_y;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sample_r <= req_sample;
      k        <= '0;
      if (32'(pair_count) > MAX_PAIRS) n_r <= CNT_W'(MAX_PAIRS);
      else n_r <= CNT_W'(pair_count);
    end else if (cmd.step) begin
      k  <= k_inc;
      x0 <= x_rd;
      y0 <= y_rd;
    end
  end

  // Operand preparation: differences in 33 bits, slope sign split off
  assign dy   = {y_rd[DATA_W-1], y_rd} - {y0[DATA_W-1], y0};
  assign dt_w = {sample_r[DATA_W-1], sample_r} - {x0[DATA_W-1], x0};
  assign dx_w = {x_rd[DATA_W-1], x_rd} - {x0[DATA_W-1], x0};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg <= dy[DATA_W];
      mag <= dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
      dt  <= dt_w[DATA_W-1:0];
      dx  <= dx_w[DATA_W-1:0];
    end
  end

  assign prod = mag * dt;

  // Restoring divide: the product's high half is already below the divisor,
  // so 32 steps leave the quotient in qsh.
  assign trial = {rem, qsh[DATA_W-1]};
  assign diff  = trial - {1'b0, dx};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem     <= prod[2*DATA_W-1:DATA_W];
      qsh     <= prod[DATA_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        qsh <= {qsh[DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        qsh <= {qsh[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign interp = neg ? (y0 - qsh) : (y0 + qsh);

  always_ff @(posedge clk) begin
    if (cmd.ld_pass) res <= sample_r;
    else if (cmd.ld_y) res <= y_rd;
    else if (cmd.ld_interp) res <= interp;
  end

  // Output register: frees the walk while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.push) begin
      out_full <= 1'b1;
    end else if (rsp_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) out_data <= res;
  end

  assign rsp_valid       = out_full;
  assign rsp_curve_value = out_data;

  assign sts.n_zero   = (n_r == '0);
  assign sts.n_one    = (n_r == CNT_W'(1));
  assign sts.hit      = ($signed(sample_r) <= $signed(x_rd));
  assign sts.last     = (k_inc == n_r);
  assign sts.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_full = out_full;

  `PLCL_ASSERT_IMP(a_rem_below_dx, clk, rst, cmd.div_step, rem < dx, "divider remainder not below divisor")
  `PLCL_ASSERT_IMP(a_seg_ascending, clk, rst, cmd.prep, $signed(x_rd) > $signed(x0), "segment divisor not positive")
  `PLCL_ASSERT_IMP(a_quot_bounded, clk, rst, cmd.ld_interp, qsh <= mag, "quotient exceeds slope magnitude")

endmodule

// File: src/piecewise_linear_curve_lookup_unit.sv
// Channel   Dir  Payload                                   Accepted when
// req       in   opcode, entry_index, sample, point_y      valid & ready
// rsp       out  curve_value                               valid & ready
// cfg       in   cfg_wr_data (pair_count)                  cfg_wr_en
//
// A write request gives no response. A lookup holds the unit while it compares
// the sample with the breakpoints in turn; an interpolation adds a multiply,
// a divide that yields one quotient bit per cycle, and a final add.
// Reset clears pair_count and the control state; breakpoints are undefined until written.
// A waiting response holds in the output register while the next request is taken; a
// further result then waits in the result state and stalls requests.
// Top level of the curve lookup unit. Depends on plcl_pkg, the channel
// interfaces, plcl_ctrl and plcl_dp.
module piecewise_linear_curve_lookup_unit import plcl_pkg::*; #(
  parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CNT_FIELD_W-1:0] cfg_wr_data,
  plcl_req_if.sink               req,
  plcl_rsp_if.source             rsp
);

  cmd_t cmd;
  sts_t sts;

  plcl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  plcl_dp #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .req_entry_index (req.entry_index),
    .req_sample      (req.sample),
    .req_point_y     (req.point_y),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_curve_value (rsp.curve_value),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for piecewise_linear_curve_lookup_unit: a directed table,
// then random breakpoint tables and lookups checked against an in-bench predictor.
// Depends on plcl_pkg, the plcl_req_if / plcl_rsp_if interfaces and the unit's RTL.
module tb_top;
  import plcl_pkg::*;

  typedef logic signed [DATA_W-1:0] q16_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_LOOKUP
  } plan_kind_t;

  typedef struct {
    plan_kind_t             kind;
    logic [CNT_FIELD_W-1:0] count;
    logic [IDX_FIELD_W-1:0] idx;
    q16_t                   sample;
    q16_t                   point_y;
    bit                     typed;
    q16_t                   want;
  } plan_row_t;

  localparam int   MAX_PAIRS    = DEF_MAX_PAIRS;
  localparam int   N_PLAN       = 30;
  localparam int   TARGET_ITEMS = 700;
  localparam int   IDLE_SETTLE  = 80;
  localparam int   DRAIN_CYCLES = 100;
  localparam int   LONG_HOLD    = 400;
  localparam int   CYCLE_LIMIT  = 1_000_000;
  localparam q16_t Q_MIN        = 32'sh8000_0000;
  localparam q16_t Q_MAX        = 32'sh7FFF_FFFF;
  localparam q16_t Q_ONE        = 32'sh0001_0000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CNT_FIELD_W-1:0] cfg_wr_data;

  plcl_req_if req_ch ();
  plcl_rsp_if rsp_ch ();

  piecewise_linear_curve_lookup_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // Predictor state: pair count and breakpoint table as the block should hold them
  logic [CNT_FIELD_W-1:0] pair_cfg;
  q16_t                   bp_x [MAX_PAIRS];
  q16_t                   bp_y [MAX_PAIRS];
  q16_t                   curve_expected_q [$];

  int fail_count      = 0;
  int results_checked = 0;
  int lookups_sent    = 0;
  int writes_sent     = 0;
  int cfg_writes      = 0;
  int burst_left      = 0;
  int cycle_count     = 0;

  // Directed table: typed expectations only where the answer is obvious
  plan_row_t directed_plan [N_PLAN] = '{
    '{ROW_CFG,    0, 0, 0,             0,             0, 0},
    '{ROW_LOOKUP, 0, 0, Q_MIN,         0,             1, Q_MIN},
    '{ROW_LOOKUP, 0, 0, Q_MAX,         0,             1, Q_MAX},
    '{ROW_LOOKUP, 0, 0, 0,             0,             1, 0},
    '{ROW_LOOKUP, 0, 0, -1,            0,             1, -1},
    '{ROW_WRITE,  0, 0, -Q_ONE,        2 * Q_ONE,     0, 0},
    '{ROW_WRITE,  0, 1, Q_ONE,         -2 * Q_ONE,    0, 0},
    '{ROW_CFG,    1, 0, 0,             0,             0, 0},
    '{ROW_LOOKUP, 0, 0, Q_MAX,         0,             1, 2 * Q_ONE},
    '{ROW_LOOKUP, 0, 0, Q_MIN,         0,             1, 2 * Q_ONE},
    '{ROW_CFG,    2, 0, 0,             0,             0, 0},
    '{ROW_LOOKUP, 0, 0, -2 * Q_ONE,    0,             1, 2 * Q_ONE},
    '{ROW_LOOKUP, 0, 0, -Q_ONE,        0,             1, 2 * Q_ONE},
    '{ROW_LOOKUP, 0, 0, Q_ONE,         0,             1, -2 * Q_ONE},
    '{ROW_LOOKUP, 0, 0, Q_MAX,         0,             1, -2 * Q_ONE},
    '{ROW_LOOKUP, 0, 0, 0,             0,             0, 0},
    '{ROW_LOOKUP, 0, 0, Q_ONE - 1,     0,             0, 0},
    '{ROW_WRITE,  0, 2, Q_ONE + 3,     -2 * Q_ONE + 2, 0, 0},
    '{ROW_WRITE,  0, 3, Q_ONE + 6,     -2 * Q_ONE,    0, 0},
    '{ROW_CFG,    4, 0, 0,             0,             0, 0},
    '{ROW_LOOKUP, 0, 0, Q_ONE + 1,     0,             0, 0},
    '{ROW_LOOKUP, 0, 0, Q_ONE + 4,     0,             0, 0},
    '{ROW_LOOKUP, 0, 0, Q_ONE + 6,     0,             1, -2 * Q_ONE},
    '{ROW_WRITE,  0, 0, Q_MIN,         Q_MAX,         0, 0},
    '{ROW_WRITE,  0, 1, Q_MAX,         Q_MIN,         0, 0},
    '{ROW_CFG,    2, 0, 0,             0,             0, 0},
    '{ROW_LOOKUP, 0, 0, Q_MIN,         0,             1, Q_MAX},
    '{ROW_LOOKUP, 0, 0, Q_MAX,         0,             1, Q_MIN},
    '{ROW_LOOKUP, 0, 0, 0,             0,             0, 0},
    '{ROW_LOOKUP, 0, 0, Q_MIN + 1,     0,             0, 0}
  };

  function automatic q16_t predict_curve(input q16_t s);
    int unsigned       n;
    int unsigned       k;
    longint            sv;
    longint            x0;
    longint            y0;
    longint            dy;
    longint            res;
    longint unsigned   mag;
    longint unsigned   dt;
    longint unsigned   dx;
    longint unsigned   q;
    n  = (pair_cfg > MAX_PAIRS) ? MAX_PAIRS : pair_cfg;
    sv = s;
    if (n == 0) return s;
    if (sv <= longint'(bp_x[0])) return bp_y[0];
    for (k = 1; k < n; k++) begin
      if (sv <= longint'(bp_x[k])) begin
        x0  = bp_x[k-1];
        y0  = bp_y[k-1];
        dy  = longint'(bp_y[k]) - y0;
        dt  = longint'(sv - x0);
        dx  = longint'(longint'(bp_x[k]) - x0);
        mag = (dy < 0) ? longint'(-dy) : longint'(dy);
        // exact product, quotient truncated toward zero
        q   = (mag * dt) / dx;
        res = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
        return q16_t'(res);
      end
    end
    return bp_y[n-1];
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender: bursts of requests with random gaps; drive at the falling edge
  task automatic send_request(input logic op, input logic [IDX_FIELD_W-1:0] idx,
                              input q16_t s, input q16_t py, input bit typed,
                              input q16_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.entry_index <= idx;
    req_ch.sample      <= s;
    req_ch.point_y     <= py;
    do @(posedge clk); while (!req_ch.ready);
    if (op == OP_WRITE) begin
      bp_x[idx] = s;
      bp_y[idx] = py;
      writes_sent++;
    end else begin
      curve_expected_q.push_back(typed ? want : predict_curve(s));
      lookups_sent++;
    end
  endtask

  // Change pair_count only once the unit has drained and gone quiet
  task automatic write_pair_count(input logic [CNT_FIELD_W-1:0] v);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (curve_expected_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    pair_cfg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned           n_eff;
    int unsigned           shape;
    int unsigned           lk_count;
    int unsigned           k;
    int unsigned           pick;
    int                    phase;
    longint unsigned       step_max;
    longint unsigned       room;
    longint unsigned       r64;
    longint                xpos;
    q16_t                  smp;
    q16_t                  ypt;
    logic [CNT_FIELD_W-1:0] cnt;

    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= OP_LOOKUP;
    req_ch.entry_index <= '0;
    req_ch.sample      <= '0;
    req_ch.point_y     <= '0;
    pair_cfg = '0;
    foreach (bp_x[i]) begin
      bp_x[i] = '0;
      bp_y[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      case (directed_plan[i].kind)
        ROW_CFG: write_pair_count(directed_plan[i].count);
        ROW_WRITE: begin
          send_request(OP_WRITE, directed_plan[i].idx, directed_plan[i].sample,
                       directed_plan[i].point_y, 1'b0, '0);
        end
        default: begin
          send_request(OP_LOOKUP, directed_plan[i].idx, directed_plan[i].sample,
                       directed_plan[i].point_y, directed_plan[i].typed,
                       directed_plan[i].want);
        end
      endcase
    end

    // Each phase: new pair count, fresh table over every entry in use, then lookups
    phase = 0;
    while (lookups_sent + writes_sent < TARGET_ITEMS) begin
      case (phase)
        0:       cnt = 6'd63;
        1:       cnt = 6'd32;
        2:       cnt = 6'd1;
        3:       cnt = 6'd0;
        4:       cnt = 6'd33;
        5:       cnt = 6'd2;
        default: cnt = ($urandom_range(0, 3) == 0) ? CNT_FIELD_W'($urandom_range(0, 63))
                                                   : CNT_FIELD_W'($urandom_range(2, 12));
      endcase
      write_pair_count(cnt);
      n_eff = (cnt > MAX_PAIRS) ? MAX_PAIRS : cnt;

      shape = $urandom_range(0, 4);
      case (shape)
        0:       step_max = 16;
        1:       step_max = 64'h2_0000;
        default: step_max = (n_eff > 1) ? 64'hFFFF_FFFF / (n_eff - 1) : 64'hFFFF_FFFF;
      endcase
      // keep the whole ascending run inside the signed range
      room = 64'h1_0000_0000 - step_max * ((n_eff > 1) ? n_eff - 1 : 0);
      r64  = {$urandom, $urandom};
      xpos = longint'(Q_MIN) + longint'(r64 % room);
      for (k = 0; k < n_eff; k++) begin
        if (k > 0) begin
          r64  = {$urandom, $urandom};
          xpos = xpos + longint'(1 + r64 % step_max);
        end
        if (shape == 4)
          ypt = k[0] ? Q_MAX : Q_MIN;
        else
          ypt = q16_t'($urandom);
        // shape 3 scrambles the x order
        smp = (shape == 3) ? q16_t'($urandom) : q16_t'(xpos);
        send_request(OP_WRITE, k[IDX_FIELD_W-1:0], smp, ypt, 1'b0, '0);
      end

      lk_count = $urandom_range(15, 45);
      repeat (lk_count) begin
        if ($urandom_range(0, 11) == 0) begin
          send_request(OP_WRITE, IDX_FIELD_W'($urandom_range(0, MAX_PAIRS - 1)),
                       q16_t'($urandom), q16_t'($urandom), 1'b0, '0);
        end else begin
          k    = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
          pick = $urandom_range(0, 9);
          case (pick)
            0: smp = bp_x[k];
            1: smp = bp_x[k] - 1;
            2: smp = bp_x[k] + 1;
            3: smp = (k > 0) ? q16_t'((longint'(bp_x[k-1]) + longint'(bp_x[k])) >>> 1)
                             : bp_x[k];
            4: smp = Q_MIN;
            5: smp = Q_MAX;
            default: smp = q16_t'($urandom);
          endcase
          send_request(OP_LOOKUP, IDX_FIELD_W'($urandom_range(0, MAX_PAIRS - 1)), smp,
                       q16_t'($urandom), 1'b0, '0);
        end
      end
      phase++;
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (curve_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d lookups and %0d breakpoint writes over %0d pair_count settings;",
             lookups_sent, writes_sent, cfg_writes);
    $display("%0d curve values compared, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("** piecewise_linear_curve_lookup_unit: PASSED **");
    end else begin
      $display("** piecewise_linear_curve_lookup_unit: FAILED **");
    end
    $finish;
  end

  // Receiver: segments of steady, random and patterned stalls, plus one long hold-off
  initial begin
    int   seg_mode;
    int   seg_left;
    int   hold_left;
    int   stall_tick;
    bit   long_hold_done;
    logic ready_next;
    seg_mode       = 0;
    seg_left       = 0;
    hold_left      = 0;
    stall_tick     = 0;
    long_hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(5, 60);
      end
      seg_left--;
      stall_tick++;
      if (hold_left > 0) begin
        ready_next = 1'b0;
        hold_left--;
      end else if (!long_hold_done && results_checked >= 40) begin
        // hold off long enough for the unit to fill and stall its requests
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        ready_next     = 1'b0;
      end else begin
        case (seg_mode)
          0:       ready_next = 1'b1;
          1:       ready_next = ($urandom_range(0, 3) != 0);
          2:       ready_next = 1'($urandom_range(0, 1));
          default: ready_next = ((stall_tick % 7) < 4);
        endcase
      end
      rsp_ch.ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    q16_t want_v;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** piecewise_linear_curve_lookup_unit: FAILED **");
      $finish;
    end else if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (curve_expected_q.size() == 0) begin
        $error("curve_value: expected no response, actual %0d (0x%h)",
               rsp_ch.curve_value, rsp_ch.curve_value);
        fail_count++;
      end else begin
        want_v = curve_expected_q.pop_front();
        if (rsp_ch.curve_value !== want_v) begin
          $error("curve_value: expected %0d (0x%h), actual %0d (0x%h)",
                 want_v, want_v, rsp_ch.curve_value, rsp_ch.curve_value);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

endmodule
